FILE: rtl/qfrm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qfrm_pkg
// Shared widths, branch codes and sideband types for the rotation matrix to
// quaternion pipeline (Q2.14 in, Q2.14 out).
// ----------------------------------------------------------------------------
package qfrm_pkg;

   // number format
   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 14;

   // front end widths
   localparam int TRACE_W = DATA_WIDTH + 2;
   localparam int RAD_W   = DATA_WIDTH + 3;
   localparam int NUM_W   = DATA_WIDTH + 1;
   localparam int N_COMP  = 4;
   localparam int N_ELEM  = 9;

   // one in the radicand format
   localparam logic signed [RAD_W-1:0] ONE_Q = RAD_W'(1 << FRAC_BITS);

   // square root unit: 2*SQ_K bit radicand, SQ_K bit root, one root bit per stage
   localparam int SQ_K    = 31;
   localparam int SQ_IN_W = 2 * SQ_K;
   localparam int SQ_RW   = SQ_K + 2;

   // divider unit: one quotient bit per stage
   localparam int DIV_LANES = N_COMP;
   localparam int DIV_N_W   = 48;
   localparam int DIV_D_W   = 32;
   localparam int DIV_Q_W   = 24;
   localparam int DIV_R_W   = DIV_D_W + 1;

   // first root and the chosen component
   localparam int ROOT1_W = DATA_WIDTH;
   localparam int HALF_W  = ROOT1_W - 1;

   // normalization
   localparam int NORM_TOP = 29;
   localparam int MAG_W    = NORM_TOP + 1;
   localparam int SHIFT_W  = 5;
   localparam int SQR_W    = 2 * MAG_W;
   localparam int SUM_W    = SQR_W + 2;
   localparam int NORM_LAT = 5;
   localparam int NORM_W   = SQ_K;

   // output saturation limits
   localparam logic [DIV_Q_W-1:0] MAX_POS = DIV_Q_W'((1 << (DATA_WIDTH - 1)) - 1);
   localparam logic [DIV_Q_W-1:0] MAX_NEG = DIV_Q_W'(1 << (DATA_WIDTH - 1));

   // largest component; the code equals the component lane (w, x, y, z)
   typedef enum logic [1:0] {
      BIG_W = 2'd0,
      BIG_X = 2'd1,
      BIG_Y = 2'd2,
      BIG_Z = 2'd3
   } big_type;

   // sideband across the first square root
   typedef struct packed {
      logic                           degen;
      big_type                        big;
      logic [N_COMP-1:0]              neg;
      logic [N_COMP-1:0][NUM_W-1:0]   amag;
   } side_a_type;

   // sideband across the first divider
   typedef struct packed {
      logic              degen;
      big_type           big;
      logic [N_COMP-1:0] neg;
      logic [HALF_W-1:0] half;
   } side_b_type;

   // sign and degenerate flag
   typedef struct packed {
      logic              degen;
      logic [N_COMP-1:0] neg;
   } flag_type;

   // sideband across the second square root
   typedef struct packed {
      logic                         degen;
      logic [N_COMP-1:0]            neg;
      logic [N_COMP-1:0][MAG_W-1:0] mag;
   } side_d_type;

endpackage
`default_nettype wire

FILE: rtl/qfrm_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qfrm_sqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qfrm_sqrt import qfrm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [SQ_IN_W-1:0] radicand,
   output logic               out_valid,
   output logic [SQ_K-1:0]    root
);

   logic [SQ_IN_W-1:0] x_ff    [SQ_K];
   logic [SQ_RW-1:0]   rem_ff  [SQ_K];
   logic [SQ_K-1:0]    root_ff [SQ_K];
   logic               v_ff    [SQ_K];

   for (genvar s = 0; s < SQ_K; s++) begin : g_step
      logic [SQ_IN_W-1:0] x_cur;
      logic [SQ_RW-1:0]   rem_cur;
      logic [SQ_K-1:0]    root_cur;
      logic               v_cur;
      logic [SQ_RW+1:0]   rem_sh;
      logic [SQ_RW+1:0]   trial;
      logic [SQ_RW+1:0]   diff;

      if (s == 0) begin : g_first
         assign x_cur    = radicand;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign v_cur    = in_valid;
      end else begin : g_next
         assign x_cur    = x_ff[s-1];
         assign rem_cur  = rem_ff[s-1];
         assign root_cur = root_ff[s-1];
         assign v_cur    = v_ff[s-1];
      end

      // bring down two radicand bits and try 4*root+1
      always_comb begin
         rem_sh = {rem_cur, x_cur[SQ_IN_W-1 -: 2]};
         trial  = {2'b00, root_cur, 2'b01};
         diff   = rem_sh - trial;
      end

      always_ff @(posedge clock) begin
         x_ff[s] <= {x_cur[SQ_IN_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff[s]  <= diff[SQ_RW-1:0];
            root_ff[s] <= {root_cur[SQ_K-2:0], 1'b1};
         end else begin
            rem_ff[s]  <= rem_sh[SQ_RW-1:0];
            root_ff[s] <= {root_cur[SQ_K-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else begin
            v_ff[s] <= v_cur;
         end
      end
   end

   assign out_valid = v_ff[SQ_K-1];
   assign root      = root_ff[SQ_K-1];

endmodule
`default_nettype wire

FILE: rtl/qfrm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qfrm_div
// Pipelined restoring divider, four lanes over one shared divisor, one
// quotient bit per stage. The quotient must fit DIV_Q_W bits.
// ----------------------------------------------------------------------------
module qfrm_div import qfrm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [DIV_D_W-1:0] divisor,
   input  logic [DIV_N_W-1:0] dividend [DIV_LANES],
   output logic               out_valid,
   output logic [DIV_Q_W-1:0] quotient [DIV_LANES]
);

   logic [DIV_D_W-1:0] d_ff   [DIV_Q_W];
   logic               v_ff   [DIV_Q_W];
   logic [DIV_Q_W-1:0] n_ff   [DIV_Q_W][DIV_LANES];
   logic [DIV_R_W-1:0] rem_ff [DIV_Q_W][DIV_LANES];
   logic [DIV_Q_W-1:0] q_ff   [DIV_Q_W][DIV_LANES];

   for (genvar s = 0; s < DIV_Q_W; s++) begin : g_step
      logic [DIV_D_W-1:0] d_cur;
      logic               v_cur;

      if (s == 0) begin : g_first
         assign d_cur = divisor;
         assign v_cur = in_valid;
      end else begin : g_next
         assign d_cur = d_ff[s-1];
         assign v_cur = v_ff[s-1];
      end

      always_ff @(posedge clock) begin
         d_ff[s] <= d_cur;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else begin
            v_ff[s] <= v_cur;
         end
      end

      for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
         logic [DIV_Q_W-1:0] n_cur;
         logic [DIV_R_W-1:0] rem_cur;
         logic [DIV_Q_W-1:0] q_cur;
         logic [DIV_R_W:0]   rem_sh;
         logic [DIV_R_W:0]   dd;
         logic [DIV_R_W:0]   diff;

         if (s == 0) begin : g_first
            assign n_cur   = dividend[l][DIV_Q_W-1:0];
            assign rem_cur = DIV_R_W'(dividend[l][DIV_N_W-1:DIV_Q_W]);
            assign q_cur   = '0;
         end else begin : g_next
            assign n_cur   = n_ff[s-1][l];
            assign rem_cur = rem_ff[s-1][l];
            assign q_cur   = q_ff[s-1][l];
         end

         // shift in next dividend bit and trial subtract
         always_comb begin
            rem_sh = {rem_cur, n_cur[DIV_Q_W-1]};
            dd     = {2'b00, d_cur};
            diff   = rem_sh - dd;
         end

         always_ff @(posedge clock) begin
            n_ff[s][l] <= {n_cur[DIV_Q_W-2:0], 1'b0};
            if (rem_sh >= dd) begin
               rem_ff[s][l] <= diff[DIV_R_W-1:0];
               q_ff[s][l]   <= {q_cur[DIV_Q_W-2:0], 1'b1};
            end else begin
               rem_ff[s][l] <= rem_sh[DIV_R_W-1:0];
               q_ff[s][l]   <= {q_cur[DIV_Q_W-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = v_ff[DIV_Q_W-1];

   always_comb begin
      for (int l = 0; l < DIV_LANES; l++) begin
         quotient[l] = q_ff[DIV_Q_W-1][l];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/qfrm_norm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qfrm_norm
// Scales the four magnitudes by one common shift so the largest lies in
// [2^29, 2^30), then forms the sum of squares. Five register stages.
// ----------------------------------------------------------------------------
module qfrm_norm import qfrm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [DIV_Q_W-1:0] mag_in [N_COMP],
   output logic               out_valid,
   output logic [MAG_W-1:0]   mag_out [N_COMP],
   output logic [SUM_W-1:0]   sum_sq
);

   logic [DIV_Q_W-1:0] all_or;
   logic [SHIFT_W-1:0] msb;
   logic [SHIFT_W-1:0] sh_in;

   logic               v_ff [NORM_LAT];
   logic [DIV_Q_W-1:0] mag1_ff [N_COMP];
   logic [SHIFT_W-1:0] sh1_ff;
   logic [MAG_W-1:0]   mag2_ff [N_COMP];
   logic [MAG_W-1:0]   mag3_ff [N_COMP];
   logic [SQR_W-1:0]   sq3_ff  [N_COMP];
   logic [MAG_W-1:0]   mag4_ff [N_COMP];
   logic [SUM_W-2:0]   pair4_ff [2];
   logic [MAG_W-1:0]   mag5_ff [N_COMP];
   logic [SUM_W-1:0]   sum5_ff;

   // leading one of the OR equals that of the largest magnitude
   always_comb begin
      all_or = '0;
      for (int i = 0; i < N_COMP; i++) begin
         all_or = all_or | mag_in[i];
      end
      msb = '0;
      for (int i = 0; i < DIV_Q_W; i++) begin
         if (all_or[i]) begin
            msb = SHIFT_W'(i);
         end
      end
      sh_in = SHIFT_W'(NORM_TOP) - msb;
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NORM_LAT; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < NORM_LAT; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // data stages: shift count, shift, square, pair sums, total
   always_ff @(posedge clock) begin
      sh1_ff <= sh_in;
      for (int i = 0; i < N_COMP; i++) begin
         mag1_ff[i] <= mag_in[i];
         mag2_ff[i] <= MAG_W'(mag1_ff[i]) << sh1_ff;
         mag3_ff[i] <= mag2_ff[i];
         sq3_ff[i]  <= SQR_W'(mag2_ff[i]) * SQR_W'(mag2_ff[i]);
         mag4_ff[i] <= mag3_ff[i];
         mag5_ff[i] <= mag4_ff[i];
      end
      pair4_ff[0] <= {1'b0, sq3_ff[0]} + {1'b0, sq3_ff[1]};
      pair4_ff[1] <= {1'b0, sq3_ff[2]} + {1'b0, sq3_ff[3]};
      sum5_ff     <= {1'b0, pair4_ff[0]} + {1'b0, pair4_ff[1]};
   end

   assign out_valid = v_ff[NORM_LAT-1];
   assign sum_sq    = sum5_ff;

   always_comb begin
      for (int i = 0; i < N_COMP; i++) begin
         mag_out[i] = mag5_ff[i];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/quaternion_from_rotation_matrix_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_from_rotation_matrix_top
// Rotation matrix (Q2.14) to unit quaternion (Q2.14), largest-component
// method with a pipelined square root, divider and renormalization.
//
//   channel   ports                       handshake
//   request   req_m00 .. req_m22          start, accepted when busy is low
//   result    rsp_quat_w/x/y/z,           rsp_valid, one cycle, no backpressure
//             rsp_degenerate
//
// One request enters every cycle; busy stays low. Each result passes through
// the two 31-stage square roots and the two 24-stage dividers (one bit per
// stage) plus front, normalize and output stages. Results leave in request
// order. Synchronous reset clears the valid bits only; the data path needs no
// reset.
// ----------------------------------------------------------------------------
module quaternion_from_rotation_matrix_top import qfrm_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_m00,
   input  logic signed [DATA_WIDTH-1:0] req_m01,
   input  logic signed [DATA_WIDTH-1:0] req_m02,
   input  logic signed [DATA_WIDTH-1:0] req_m10,
   input  logic signed [DATA_WIDTH-1:0] req_m11,
   input  logic signed [DATA_WIDTH-1:0] req_m12,
   input  logic signed [DATA_WIDTH-1:0] req_m20,
   input  logic signed [DATA_WIDTH-1:0] req_m21,
   input  logic signed [DATA_WIDTH-1:0] req_m22,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_w,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_x,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_y,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_z,
   output logic                         rsp_degenerate
);

   // input register
   logic                         in_valid_ff;
   logic signed [DATA_WIDTH-1:0] m_ff [N_ELEM];

   // front stage
   logic signed [TRACE_W-1:0] trace;
   logic signed [RAD_W-1:0]   rad_in;
   logic signed [NUM_W-1:0]   num_in [N_COMP];
   big_type                   big_in;
   logic                      s1_valid_ff;
   logic signed [RAD_W-1:0]   rad_ff;
   logic signed [NUM_W-1:0]   num_ff [N_COMP];
   big_type                   big_ff;

   // first root
   logic               rad_pos;
   logic [SQ_IN_W-1:0] sq1_x;
   side_a_type         side_a_in;
   side_a_type         side_a_ff [SQ_K];
   logic               sq1_valid;
   logic [SQ_K-1:0]    sq1_root;

   // first divide
   logic [ROOT1_W-1:0] r1;
   logic [DIV_D_W-1:0] div1_d;
   logic [DIV_N_W-1:0] div1_n [DIV_LANES];
   side_b_type         side_b_in;
   side_b_type         side_b_ff [DIV_Q_W];
   logic               div1_valid;
   logic [DIV_Q_W-1:0] div1_q [DIV_LANES];

   // normalize
   logic [DIV_Q_W-1:0] mag_in [N_COMP];
   flag_type           side_c_in;
   flag_type           side_c_ff [NORM_LAT];
   logic               norm_valid;
   logic [MAG_W-1:0]   norm_mag [N_COMP];
   logic [SUM_W-1:0]   norm_sum;

   // second root
   side_d_type         side_d_in;
   side_d_type         side_d_ff [SQ_K];
   logic               sq2_valid;
   logic [SQ_K-1:0]    sq2_root;

   // second divide
   logic [DIV_D_W-1:0] div2_d;
   logic [DIV_N_W-1:0] div2_n [DIV_LANES];
   flag_type           side_e_in;
   flag_type           side_e_ff [DIV_Q_W];
   logic               div2_valid;
   logic [DIV_Q_W-1:0] div2_q [DIV_LANES];

   // output
   logic [DATA_WIDTH-1:0] quat_in [N_COMP];
   logic [DIV_Q_W-1:0]    sat;

   assign busy = 1'b0;

   // capture request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      m_ff[0] <= req_m00;
      m_ff[1] <= req_m01;
      m_ff[2] <= req_m02;
      m_ff[3] <= req_m10;
      m_ff[4] <= req_m11;
      m_ff[5] <= req_m12;
      m_ff[6] <= req_m20;
      m_ff[7] <= req_m21;
      m_ff[8] <= req_m22;
   end

   // branch select, radicand and numerators
   always_comb begin
      trace = TRACE_W'(m_ff[0]) + TRACE_W'(m_ff[4]) + TRACE_W'(m_ff[8]);
      if (trace > 0) begin
         big_in    = BIG_W;
         rad_in    = RAD_W'(trace) + ONE_Q;
         num_in[0] = '0;
         num_in[1] = NUM_W'(m_ff[7]) - NUM_W'(m_ff[5]);
         num_in[2] = NUM_W'(m_ff[2]) - NUM_W'(m_ff[6]);
         num_in[3] = NUM_W'(m_ff[3]) - NUM_W'(m_ff[1]);
      end else if (m_ff[0] > m_ff[4] && m_ff[0] > m_ff[8]) begin
         big_in    = BIG_X;
         rad_in    = ONE_Q + RAD_W'(m_ff[0]) - RAD_W'(m_ff[4]) - RAD_W'(m_ff[8]);
         num_in[0] = NUM_W'(m_ff[7]) - NUM_W'(m_ff[5]);
         num_in[1] = '0;
         num_in[2] = NUM_W'(m_ff[1]) + NUM_W'(m_ff[3]);
         num_in[3] = NUM_W'(m_ff[2]) + NUM_W'(m_ff[6]);
      end else if (m_ff[4] > m_ff[8]) begin
         big_in    = BIG_Y;
         rad_in    = ONE_Q + RAD_W'(m_ff[4]) - RAD_W'(m_ff[0]) - RAD_W'(m_ff[8]);
         num_in[0] = NUM_W'(m_ff[2]) - NUM_W'(m_ff[6]);
         num_in[1] = NUM_W'(m_ff[1]) + NUM_W'(m_ff[3]);
         num_in[2] = '0;
         num_in[3] = NUM_W'(m_ff[5]) + NUM_W'(m_ff[7]);
      end else begin
         big_in    = BIG_Z;
         rad_in    = ONE_Q + RAD_W'(m_ff[8]) - RAD_W'(m_ff[4]) - RAD_W'(m_ff[0]);
         num_in[0] = NUM_W'(m_ff[3]) - NUM_W'(m_ff[1]);
         num_in[1] = NUM_W'(m_ff[2]) + NUM_W'(m_ff[6]);
         num_in[2] = NUM_W'(m_ff[7]) + NUM_W'(m_ff[5]);
         num_in[3] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      big_ff <= big_in;
      for (int i = 0; i < N_COMP; i++) begin
         num_ff[i] <= num_in[i];
      end
   end

   // first root on rad << FRAC_BITS, signs and magnitudes ride alongside
   always_comb begin
      rad_pos         = rad_ff > 0;
      sq1_x           = rad_pos ? SQ_IN_W'({rad_ff[RAD_W-2:0], FRAC_BITS'(0)}) : '0;
      side_a_in.degen = !rad_pos;
      side_a_in.big   = big_ff;
      for (int i = 0; i < N_COMP; i++) begin
         side_a_in.neg[i]  = num_ff[i][NUM_W-1];
         side_a_in.amag[i] = num_ff[i][NUM_W-1] ? NUM_W'(-num_ff[i]) : NUM_W'(num_ff[i]);
      end
   end

   qfrm_sqrt u_sqrt1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .radicand  (sq1_x),
      .out_valid (sq1_valid),
      .root      (sq1_root)
   );

   always_ff @(posedge clock) begin
      side_a_ff[0] <= side_a_in;
      for (int i = 1; i < SQ_K; i++) begin
         side_a_ff[i] <= side_a_ff[i-1];
      end
   end

   // divide numerators by 2r
   always_comb begin
      r1     = sq1_root[ROOT1_W-1:0];
      div1_d = DIV_D_W'({r1, 1'b0});
      for (int i = 0; i < DIV_LANES; i++) begin
         div1_n[i] = DIV_N_W'({side_a_ff[SQ_K-1].amag[i], FRAC_BITS'(0)});
      end
      side_b_in.degen = side_a_ff[SQ_K-1].degen;
      side_b_in.big   = side_a_ff[SQ_K-1].big;
      side_b_in.neg   = side_a_ff[SQ_K-1].neg;
      side_b_in.half  = r1[ROOT1_W-1:1];
   end

   qfrm_div u_div1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq1_valid),
      .divisor   (div1_d),
      .dividend  (div1_n),
      .out_valid (div1_valid),
      .quotient  (div1_q)
   );

   always_ff @(posedge clock) begin
      side_b_ff[0] <= side_b_in;
      for (int i = 1; i < DIV_Q_W; i++) begin
         side_b_ff[i] <= side_b_ff[i-1];
      end
   end

   // chosen component is r/2, the others are quotients
   always_comb begin
      for (int i = 0; i < N_COMP; i++) begin
         if (side_b_ff[DIV_Q_W-1].big == big_type'(i)) begin
            mag_in[i] = DIV_Q_W'(side_b_ff[DIV_Q_W-1].half);
         end else begin
            mag_in[i] = div1_q[i];
         end
      end
      side_c_in.degen = side_b_ff[DIV_Q_W-1].degen;
      side_c_in.neg   = side_b_ff[DIV_Q_W-1].neg;
   end

   qfrm_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div1_valid),
      .mag_in    (mag_in),
      .out_valid (norm_valid),
      .mag_out   (norm_mag),
      .sum_sq    (norm_sum)
   );

   always_ff @(posedge clock) begin
      side_c_ff[0] <= side_c_in;
      for (int i = 1; i < NORM_LAT; i++) begin
         side_c_ff[i] <= side_c_ff[i-1];
      end
   end

   // second root gives the norm
   always_comb begin
      side_d_in.degen = side_c_ff[NORM_LAT-1].degen;
      side_d_in.neg   = side_c_ff[NORM_LAT-1].neg;
      for (int i = 0; i < N_COMP; i++) begin
         side_d_in.mag[i] = norm_mag[i];
      end
   end

   qfrm_sqrt u_sqrt2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .radicand  (norm_sum),
      .out_valid (sq2_valid),
      .root      (sq2_root)
   );

   always_ff @(posedge clock) begin
      side_d_ff[0] <= side_d_in;
      for (int i = 1; i < SQ_K; i++) begin
         side_d_ff[i] <= side_d_ff[i-1];
      end
   end

   // divide each scaled magnitude by the norm
   always_comb begin
      div2_d = DIV_D_W'(sq2_root);
      for (int i = 0; i < DIV_LANES; i++) begin
         div2_n[i] = DIV_N_W'({side_d_ff[SQ_K-1].mag[i], FRAC_BITS'(0)});
      end
      side_e_in.degen = side_d_ff[SQ_K-1].degen || (sq2_root == '0);
      side_e_in.neg   = side_d_ff[SQ_K-1].neg;
   end

   qfrm_div u_div2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq2_valid),
      .divisor   (div2_d),
      .dividend  (div2_n),
      .out_valid (div2_valid),
      .quotient  (div2_q)
   );

   always_ff @(posedge clock) begin
      side_e_ff[0] <= side_e_in;
      for (int i = 1; i < DIV_Q_W; i++) begin
         side_e_ff[i] <= side_e_ff[i-1];
      end
   end

   // saturate, apply sign, force zero when degenerate
   always_comb begin
      sat = '0;
      for (int i = 0; i < N_COMP; i++) begin
         if (side_e_ff[DIV_Q_W-1].neg[i]) begin
            sat        = (div2_q[i] > MAX_NEG) ? MAX_NEG : div2_q[i];
            quat_in[i] = DATA_WIDTH'(-sat);
         end else begin
            sat        = (div2_q[i] > MAX_POS) ? MAX_POS : div2_q[i];
            quat_in[i] = DATA_WIDTH'(sat);
         end
         if (side_e_ff[DIV_Q_W-1].degen) begin
            quat_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= div2_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_quat_w     <= quat_in[0];
      rsp_quat_x     <= quat_in[1];
      rsp_quat_y     <= quat_in[2];
      rsp_quat_z     <= quat_in[3];
      rsp_degenerate <= side_e_ff[DIV_Q_W-1].degen;
   end

endmodule
`default_nettype wire
